// File: design/cfsf_pkg.sv
// Shared types, constants and functions for the config frame stream filter.
// Used by the controller, datapath and top level; depends on nothing else.
`default_nettype none

package cfsf_pkg;

  localparam int MAX_PAYLOAD_DEF = 20;
  localparam int FRAME_OVERHEAD = 20;
  localparam int HDR_LEN = 12;
  localparam int MAGIC_LEN = 8;
  localparam int CRC_TAIL = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 2;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [7:0] CMD_HELLO = 8'd1;
  localparam logic [7:0] PROTO_VERSION = 8'd1;

  localparam logic [1:0] PHASE_DISCOVERY = 2'd0;
  localparam logic [1:0] PHASE_SWITCH = 2'd1;
  localparam logic [1:0] PHASE_SESSION = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LINK_PHASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOVERY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD = 2'd2;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;
  localparam logic KIND_PASS = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_LOAD,
    ST_EXTRA
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic rd_step;
    logic load_stream;
    logic load_extra;
  } ctl_cmd_t;

  typedef struct packed {
    logic plan_stream;
    logic plan_extra;
    logic extra_pend;
    logic stream_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h54;
      3'd1: c = 8'h4B;
      3'd2: c = 8'h45;
      3'd3: c = 8'h4C;
      3'd4: c = 8'h52;
      3'd5: c = 8'h53;
      3'd6: c = 8'h43;
      3'd7: c = 8'h46;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/cfsf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the partial frame; depends on nothing else.
`default_nettype none

module cfsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/cfsf_datapath.sv
// Datapath: configuration registers, frame parser state, CRC, frame buffer
// and output register. Depends on cfsf_pkg and cfsf_ram.
`default_nettype none

module cfsf_datapath #(
  parameter int MAX_PAYLOAD = cfsf_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                action,
  input  wire logic [7:0]                          byte_value,
  input  wire logic                                cfg_we,
  input  wire logic [cfsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cfsf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic                                     out_kind,
  output logic [7:0]                               out_byte,
  output logic                                     out_last,
  input  wire cfsf_pkg::ctl_cmd_t                  cmd,
  output cfsf_pkg::dp_status_t                     status
);

  localparam int DEPTH = cfsf_pkg::FRAME_OVERHEAD + MAX_PAYLOAD;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  logic [1:0]        link_phase;
  logic              discovery_enabled;
  logic              forward_enable;
  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  expected_length;
  logic [31:0]       running_crc;
  logic              frame_held;
  logic              version_ok;
  logic              cmd_hello;
  logic [31:0]       crc_got;
  logic [7:0]        byte_reg;
  logic              action_reg;
  logic [CNT_W-1:0]  stream_len;
  logic              stream_kind;
  logic              extra_pend;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        ram_rdata;

  logic              p_wr;
  logic [ADDR_W-1:0] p_wr_addr;
  logic              p_keep;
  logic              p_clear;
  logic              p_restart;
  logic [CNT_W-1:0]  fill_next;
  logic [CNT_W-1:0]  expected_next;
  logic [31:0]       crc_next;
  logic [31:0]       got_next;
  logic [CNT_W-1:0]  p_stream_len;
  logic              p_stream_kind;
  logic              p_extra;
  logic              p_held_set;
  logic              p_held_clr;

  logic [31:0]       crc_b;
  logic              crc_upd;
  logic              hdr_done;
  logic              complete;
  logic              allowed;
  logic              good;
  logic              cfg_hit;
  logic [CNT_W-1:0]  fwd_fill;

  assign crc_b = cfsf_pkg::crc_byte(running_crc, byte_reg);
  assign cfg_hit = cfg_we && (cfg_index == cfsf_pkg::REG_LINK_PHASE ||
                              cfg_index == cfsf_pkg::REG_DISCOVERY ||
                              cfg_index == cfsf_pkg::REG_FORWARD);

  always_comb begin
    p_wr = 1'b0;
    p_wr_addr = fill_count[ADDR_W-1:0];
    p_keep = 1'b0;
    p_clear = 1'b0;
    p_restart = 1'b0;
    p_stream_len = '0;
    p_stream_kind = cfsf_pkg::KIND_PASS;
    p_extra = 1'b0;
    p_held_set = 1'b0;
    p_held_clr = 1'b0;
    crc_upd = (expected_length == '0) ||
              (({1'b0, fill_count} + (CNT_W + 1)'(cfsf_pkg::CRC_TAIL)) <
               {1'b0, expected_length});
    fill_next = fill_count + CNT_W'(1);
    crc_next = crc_upd ? crc_b : running_crc;
    got_next = {byte_reg, crc_got[31:8]};
    hdr_done = (fill_next == CNT_W'(cfsf_pkg::HDR_LEN));
    expected_next = hdr_done ?
        CNT_W'(9'(cfsf_pkg::FRAME_OVERHEAD) + {1'b0, byte_reg}) : expected_length;
    complete = (expected_next != '0) && (fill_next == expected_next);
    allowed = (link_phase == cfsf_pkg::PHASE_SESSION) ||
              (link_phase == cfsf_pkg::PHASE_DISCOVERY && cmd_hello);
    good = version_ok && (got_next == ~crc_next);
    fwd_fill = forward_enable ? fill_count : '0;

    if (action_reg == cfsf_pkg::ACT_RELEASE) begin
      p_held_clr = 1'b1;
    end else if (link_phase == cfsf_pkg::PHASE_DISCOVERY && !discovery_enabled) begin
      p_extra = forward_enable;
    end else if (fill_count < CNT_W'(cfsf_pkg::MAGIC_LEN) &&
                 byte_reg != cfsf_pkg::magic_char(fill_count[2:0])) begin
      p_stream_len = fwd_fill;
      if (byte_reg == cfsf_pkg::magic_char(3'd0)) begin
        p_restart = 1'b1;
        p_wr = 1'b1;
        p_wr_addr = '0;
      end else begin
        p_clear = 1'b1;
        p_extra = forward_enable;
      end
    end else if (fill_count >= CNT_W'(DEPTH)) begin
      p_stream_len = fwd_fill;
      p_clear = 1'b1;
    end else begin
      p_wr = 1'b1;
      if (hdr_done && byte_reg > 8'(MAX_PAYLOAD)) begin
        p_stream_len = forward_enable ? fill_next : '0;
        p_clear = 1'b1;
      end else if (complete) begin
        p_clear = 1'b1;
        if (allowed && !frame_held && good) begin
          p_stream_len = fill_next;
          p_stream_kind = cfsf_pkg::KIND_FRAME;
          p_held_set = 1'b1;
        end else begin
          p_stream_len = forward_enable ? fill_next : '0;
        end
      end else begin
        p_keep = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_phase <= cfsf_pkg::PHASE_DISCOVERY;
      discovery_enabled <= 1'b0;
      forward_enable <= 1'b1;
      fill_count <= '0;
      expected_length <= '0;
      running_crc <= cfsf_pkg::CRC_INIT;
      frame_held <= 1'b0;
    end else if (cfg_hit) begin
      case (cfg_index)
        cfsf_pkg::REG_LINK_PHASE: link_phase <= cfg_data;
        cfsf_pkg::REG_DISCOVERY: discovery_enabled <= cfg_data[0];
        cfsf_pkg::REG_FORWARD: forward_enable <= cfg_data[0];
        default: ;
      endcase
      fill_count <= '0;
      expected_length <= '0;
      running_crc <= cfsf_pkg::CRC_INIT;
    end else if (cmd.eval) begin
      if (p_held_clr) begin
        frame_held <= 1'b0;
      end else if (p_held_set) begin
        frame_held <= 1'b1;
      end
      if (p_keep) begin
        fill_count <= fill_next;
        expected_length <= expected_next;
        running_crc <= crc_next;
      end else if (p_restart) begin
        fill_count <= CNT_W'(1);
        expected_length <= '0;
        running_crc <= cfsf_pkg::crc_byte(cfsf_pkg::CRC_INIT, cfsf_pkg::magic_char(3'd0));
      end else if (p_clear) begin
        fill_count <= '0;
        expected_length <= '0;
        running_crc <= cfsf_pkg::CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_reg <= byte_value;
      action_reg <= action;
    end
    if (cmd.eval) begin
      stream_len <= p_stream_len;
      stream_kind <= p_stream_kind;
      extra_pend <= p_extra;
      rd_addr <= '0;
      if (p_keep) begin
        crc_got <= got_next;
        if (fill_count == CNT_W'(cfsf_pkg::MAGIC_LEN)) begin
          version_ok <= (byte_reg == cfsf_pkg::PROTO_VERSION);
        end
        if (fill_count == CNT_W'(cfsf_pkg::MAGIC_LEN + 1)) begin
          cmd_hello <= (byte_reg == cfsf_pkg::CMD_HELLO);
        end
      end
    end else if (cmd.rd_step) begin
      rd_addr <= rd_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_stream || cmd.load_extra) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_stream) begin
      out_kind <= stream_kind;
      out_byte <= ram_rdata;
      out_last <= status.stream_last && !extra_pend;
    end else if (cmd.load_extra) begin
      out_kind <= cfsf_pkg::KIND_PASS;
      out_byte <= byte_reg;
      out_last <= 1'b1;
    end
  end

  cfsf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.eval && p_wr),
    .waddr(p_wr_addr),
    .wdata(byte_reg),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  assign status.plan_stream = (p_stream_len != '0);
  assign status.plan_extra = p_extra;
  assign status.extra_pend = extra_pend;
  assign status.stream_last = (CNT_W'(rd_addr) + CNT_W'(1) == stream_len);
  assign status.out_free = !out_valid || out_ready;

  a_fill_below_expected: assert property (@(posedge clk) disable iff (rst)
    expected_length != '0 |-> fill_count < expected_length)
    else $error("fill count reached the expected frame length without resolving");

  a_held_from_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(frame_held) |-> $past(cmd.eval))
    else $error("frame hold set outside of an evaluation cycle");

  a_frame_stream_len: assert property (@(posedge clk) disable iff (rst)
    cmd.load_stream && stream_kind == cfsf_pkg::KIND_FRAME |-> frame_held)
    else $error("frame bytes emitted without the frame being held");

endmodule

`default_nettype wire

// File: design/cfsf_ctrl.sv
// Controller state machine: input handshake, evaluation and output sequencing.
// Depends on cfsf_pkg.
`default_nettype none

module cfsf_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire cfsf_pkg::dp_status_t status,
  output cfsf_pkg::ctl_cmd_t        cmd
);

  cfsf_pkg::ctl_state_t state;
  cfsf_pkg::ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfsf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      cfsf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = cfsf_pkg::ST_EVAL;
        end
      end
      cfsf_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
        if (status.plan_stream) begin
          state_next = cfsf_pkg::ST_READ;
        end else if (status.plan_extra) begin
          if (status.out_free) begin
            cmd.load_extra = 1'b1;
            state_next = cfsf_pkg::ST_IDLE;
          end else begin
            state_next = cfsf_pkg::ST_EXTRA;
          end
        end else begin
          state_next = cfsf_pkg::ST_IDLE;
        end
      end
      cfsf_pkg::ST_READ: begin
        state_next = cfsf_pkg::ST_LOAD;
      end
      cfsf_pkg::ST_LOAD: begin
        if (status.out_free) begin
          cmd.load_stream = 1'b1;
          if (!status.stream_last) begin
            cmd.rd_step = 1'b1;
            state_next = cfsf_pkg::ST_READ;
          end else if (status.extra_pend) begin
            state_next = cfsf_pkg::ST_EXTRA;
          end else begin
            state_next = cfsf_pkg::ST_IDLE;
          end
        end
      end
      cfsf_pkg::ST_EXTRA: begin
        if (status.out_free) begin
          cmd.load_extra = 1'b1;
          state_next = cfsf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cfsf_pkg::ST_IDLE;
      end
    endcase
  end

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_stream || cmd.load_extra) |-> status.out_free)
    else $error("output register loaded while still occupied");

  a_capture_then_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.eval)
    else $error("captured transaction was not evaluated in the next cycle");

  a_single_load: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_stream && cmd.load_extra))
    else $error("two output loads requested in one cycle");

endmodule

`default_nettype wire

// File: design/config_frame_stream_filter.sv
// Top level of the config frame stream filter: joins controller and datapath.
// Depends on cfsf_pkg, cfsf_ctrl, cfsf_datapath and cfsf_ram.
//
//   Channel  Handshake               Payload
//   input    in_valid / in_ready     action, byte_value
//   output   out_valid / out_ready   out_kind, out_byte, out_last
//   config   cfg_we                  cfg_index, cfg_data
//
// A release or pass-through byte needs only the IDLE and EVAL states when the
// output register is free. A replay or accepted frame adds READ and LOAD for
// each buffered byte, since each byte is read from the frame buffer with a
// registered read. A magic mismatch that forwards its own byte after the
// replay also passes through EXTRA.
// Reset clears control state; the frame buffer needs no clearing pass.
// A stalled output holds the sequencer; in_ready is low until it finishes.
`default_nettype none

module config_frame_stream_filter #(
  parameter int MAX_PAYLOAD = cfsf_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            action,
  input  wire logic [7:0]                      byte_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_kind,
  output logic [7:0]                           out_byte,
  output logic                                 out_last,
  input  wire logic                            cfg_we,
  input  wire logic [cfsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cfsf_pkg::CFG_DATA_W-1:0] cfg_data
);

  cfsf_pkg::ctl_cmd_t   cmd;
  cfsf_pkg::dp_status_t status;

  cfsf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  cfsf_datapath #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .action    (action),
    .byte_value(byte_value),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

// File: tb/config_frame_stream_filter_test.sv
// Self-checking testbench for config_frame_stream_filter: byte stream in, filtered stream out.
// A behavioral predictor of the frame parser checks every output transaction in order.
// Depends on cfsf_pkg and the config_frame_stream_filter RTL.
module config_frame_stream_filter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cfsf_pkg::*;

  localparam int STORE_DEPTH = FRAME_OVERHEAD + MAX_PAYLOAD_DEF;
  localparam int CHALLENGE_LEN = FRAME_OVERHEAD - HDR_LEN - CRC_TAIL;
  localparam int SETTLE_CYCLES = 2 + 2 * STORE_DEPTH + 20;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ROUNDS = 6;
  localparam int ROUND_ITEMS = 1;
  localparam logic [63:0] FRAME_TAG = "TKELRSCF";
  localparam logic [1:0] PHASE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic kind;
    logic [7:0] data;
    logic last;
  } out_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = ACT_BYTE;
  logic [7:0] byte_value = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_kind;
  logic [7:0] out_byte;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [7:0] rx_buf [STORE_DEPTH];
  int unsigned rx_fill = 0;
  int unsigned rx_frame_len = 0;
  logic [31:0] rx_crc = '1;
  bit frame_held = 1'b0;
  logic [1:0] link_phase = PHASE_DISCOVERY;
  bit discovery_on = 1'b0;
  bit forward_on = 1'b1;
  out_beat_t step_beats[$];
  out_beat_t expected_beats[$];
  out_beat_t want_beat;

  bit idle_on = 1'b1;
  bit stall_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned sent_items = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  config_frame_stream_filter #(
    .MAX_PAYLOAD(MAX_PAYLOAD_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .byte_value(byte_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_byte(out_byte),
    .out_last(out_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    logic fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic logic [7:0] tag_byte(input int unsigned pos);
    return FRAME_TAG[63 - 8 * pos -: 8];
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_partial();
    rx_fill = 0;
    rx_frame_len = 0;
    rx_crc = '1;
  endfunction

  function automatic void add_beat(input logic kind, input logic [7:0] data);
    step_beats.push_back({kind, data, 1'b0});
  endfunction

  function automatic void replay_partial();
    if (forward_on) begin
      for (int unsigned i = 0; i < rx_fill && i < STORE_DEPTH; i++) add_beat(KIND_PASS, rx_buf[i]);
    end
    clear_partial();
  endfunction

  // Works out the output transactions caused by one accepted input transaction.
  function automatic void predict_filter(input logic act, input logic [7:0] b);
    int unsigned e;
    logic [31:0] rx_sum;
    bit cmd_ok;
    bit frame_ok;
    bit done;
    out_beat_t last_beat;
    step_beats.delete();
    done = 1'b0;
    if (act == ACT_RELEASE) begin
      frame_held = 1'b0;
      return;
    end
    if (link_phase == PHASE_DISCOVERY && !discovery_on) begin
      if (forward_on) add_beat(KIND_PASS, b);
      done = 1'b1;
    end else if (rx_fill < MAGIC_LEN && b != tag_byte(rx_fill)) begin
      replay_partial();
      if (b == tag_byte(0)) begin
        rx_buf[0] = b;
        rx_fill = 1;
        rx_crc = crc_next(rx_crc, b);
      end else if (forward_on) begin
        add_beat(KIND_PASS, b);
      end
      done = 1'b1;
    end else if (rx_fill >= STORE_DEPTH) begin
      replay_partial();
      done = 1'b1;
    end
    if (!done) begin
      rx_buf[rx_fill] = b;
      if (rx_frame_len == 0 || rx_fill + CRC_TAIL < rx_frame_len) rx_crc = crc_next(rx_crc, b);
      rx_fill++;
      if (rx_fill == HDR_LEN) begin
        if (rx_buf[HDR_LEN - 1] > MAX_PAYLOAD_DEF) begin
          replay_partial();
          done = 1'b1;
        end else begin
          rx_frame_len = FRAME_OVERHEAD + rx_buf[HDR_LEN - 1];
        end
      end
    end
    if (!done && rx_frame_len != 0 && rx_fill == rx_frame_len) begin
      e = rx_frame_len;
      rx_sum = {rx_buf[e - 1], rx_buf[e - 2], rx_buf[e - 3], rx_buf[e - 4]};
      cmd_ok = (link_phase == PHASE_SESSION) ||
               (link_phase == PHASE_DISCOVERY && rx_buf[MAGIC_LEN + 1] == CMD_HELLO);
      frame_ok = (rx_buf[MAGIC_LEN] == PROTO_VERSION) && (rx_sum == ~rx_crc);
      if (cmd_ok && frame_ok && !frame_held) begin
        for (int unsigned i = 0; i < e; i++) add_beat(KIND_FRAME, rx_buf[i]);
        frame_held = 1'b1;
        clear_partial();
      end else begin
        replay_partial();
      end
    end
    if (step_beats.size() != 0) begin
      last_beat = step_beats.pop_back();
      last_beat.last = 1'b1;
      step_beats.push_back(last_beat);
    end
    foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_LINK_PHASE: link_phase = val;
      REG_DISCOVERY: discovery_on = val[0];
      REG_FORWARD: forward_on = val[0];
      default: return;
    endcase
    clear_partial();
  endfunction

  task automatic settle(input int extra);
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle(SETTLE_CYCLES);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic send_item(input logic act, input logic [7:0] val);
    int gap;
    gap = idle_on ? pick_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    byte_value <= val;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_filter(act, val);
    sent_items++;
  endtask

  task automatic send_tag_prefix(input int keep);
    for (int i = 0; i < keep; i++) send_item(ACT_BYTE, tag_byte(i));
  endtask

  // A length above the payload limit sends the header alone.
  task automatic send_frame(input logic [7:0] version, input logic [7:0] command,
                            input logic [7:0] length, input bit corrupt_crc);
    logic [7:0] frame_bytes[$];
    logic [31:0] sum;
    for (int i = 0; i < MAGIC_LEN; i++) frame_bytes.push_back(tag_byte(i));
    frame_bytes.push_back(version);
    frame_bytes.push_back(command);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(length);
    if (length <= MAX_PAYLOAD_DEF) begin
      repeat (CHALLENGE_LEN + length) frame_bytes.push_back(8'($urandom));
      sum = '1;
      foreach (frame_bytes[i]) sum = crc_next(sum, frame_bytes[i]);
      sum = ~sum;
      if (corrupt_crc) sum = sum ^ (32'h1 << $urandom_range(0, 31));
      for (int i = 0; i < CRC_TAIL; i++) frame_bytes.push_back(sum[8 * i +: 8]);
    end
    foreach (frame_bytes[i]) send_item(ACT_BYTE, frame_bytes[i]);
  endtask

  task automatic send_random_sequence();
    int pick;
    logic [7:0] version;
    logic [7:0] length;
    pick = $urandom_range(0, 99);
    length = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 3)) :
                                            8'($urandom_range(4, MAX_PAYLOAD_DEF));
    version = 8'($urandom);
    if (version == PROTO_VERSION) version = 8'h00;
    if ($urandom_range(0, 9) == 0) settle(0);
    if (pick < 45) begin
      send_frame(PROTO_VERSION, $urandom_range(0, 1) ? CMD_HELLO : 8'($urandom), length, 1'b0);
      if ($urandom_range(0, 4) < 3) send_item(ACT_RELEASE, 8'($urandom));
    end else if (pick < 52) begin
      send_frame(version, CMD_HELLO, length, 1'b0);
    end else if (pick < 60) begin
      send_frame(PROTO_VERSION, CMD_HELLO, length, 1'b1);
    end else if (pick < 68) begin
      send_frame(PROTO_VERSION, 8'($urandom), 8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)), 1'b0);
    end else if (pick < 85) begin
      send_tag_prefix($urandom_range(0, MAGIC_LEN - 1));
      send_item(ACT_BYTE, ($urandom_range(0, 2) == 0) ? tag_byte(0) : 8'($urandom));
    end else if (pick < 93) begin
      send_item(ACT_RELEASE, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) send_item(ACT_BYTE, 8'($urandom));
    end
  endtask

  task automatic test_transparent_path();
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, 8'hFF);
    send_item(ACT_BYTE, tag_byte(0));
    send_item(ACT_RELEASE, 8'hFF);
    send_item(ACT_BYTE, 8'h5A);
    write_reg(REG_NONE, 2'b11);
    send_item(ACT_BYTE, 8'hA5);
  endtask

  task automatic test_hello_handshake();
    write_reg(REG_DISCOVERY, 2'b01);
    send_frame(PROTO_VERSION, CMD_HELLO, 8'd0, 1'b0);
    send_frame(PROTO_VERSION, CMD_HELLO, 8'd0, 1'b0);
    send_item(ACT_RELEASE, 8'h00);
  endtask

  task automatic test_malformed_frames();
    write_reg(REG_LINK_PHASE, PHASE_SESSION);
    send_tag_prefix(3);
    send_item(ACT_BYTE, tag_byte(0));
    send_item(ACT_BYTE, 8'h00);
    send_frame(PROTO_VERSION, CMD_HELLO, 8'hFF, 1'b0);
    send_frame(PROTO_VERSION, CMD_HELLO, 8'(MAX_PAYLOAD_DEF), 1'b1);
    send_tag_prefix(5);
  endtask

  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] phase;
    logic [CFG_DATA_W-1:0] disc;
    logic [CFG_DATA_W-1:0] fwd;
    int unsigned stop_at;
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      phase = 2'($urandom);
      disc = 2'($urandom_range(1, 3));
      fwd = 2'($urandom);
      case (round)
        0: begin
          phase = PHASE_SESSION;
          disc = 2'b01;
          fwd = 2'b01;
        end
        1: begin
          phase = PHASE_DISCOVERY;
          disc = 2'b01;
          fwd = 2'b11;
        end
        2: begin
          phase = PHASE_SWITCH;
          fwd = 2'b01;
        end
        3: begin
          phase = PHASE_UNUSED;
          fwd = 2'b00;
        end
        4: begin
          phase = PHASE_DISCOVERY;
          disc = 2'b00;
        end
        5: begin
          phase = PHASE_SESSION;
          fwd = 2'b10;
        end
        default: ;
      endcase
      idle_on = (round != 0);
      stall_on = (round != 0);
      write_reg(REG_FORWARD, fwd);
      write_reg(REG_DISCOVERY, disc);
      write_reg(REG_LINK_PHASE, phase);
      stop_at = sent_items + ROUND_ITEMS;
      while (sent_items < stop_at) send_random_sequence();
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (stall_on) stall_left = pick_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("out_byte expected no transaction, actual 0x%02h (out_kind %0d)", out_byte, out_kind);
        error_count++;
      end else begin
        want_beat = expected_beats.pop_front();
        if (out_kind !== want_beat.kind) begin
          $error("out_kind expected %0d actual %0d", want_beat.kind, out_kind);
          error_count++;
        end
        if (out_byte !== want_beat.data) begin
          $error("out_byte expected 0x%02h actual 0x%02h", want_beat.data, out_byte);
          error_count++;
        end
        if (out_last !== want_beat.last) begin
          $error("out_last expected %0d actual %0d", want_beat.last, out_last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_transparent_path();
    test_hello_handshake();
    test_malformed_frames();
    test_random_traffic();
    settle(SETTLE_CYCLES);
    if (error_count == 0 && expected_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
